// ===== sv/lfd_pkg.sv =====
// Package for the linear fade dimmer: widths, codes, transaction types and helpers.
package lfd_pkg;

  localparam int unsigned FRAC_BITS = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned LEVEL_W   = BYTE_W + FRAC_BITS;
  localparam int unsigned STEP_W    = LEVEL_W + 1;
  localparam int unsigned SUM_W     = LEVEL_W + 2;
  localparam int unsigned DIV_W     = TIME_W;
  localparam int unsigned REM_W     = DIV_W + 1;
  localparam int unsigned CNT_W     = $clog2(LEVEL_W);

  localparam logic [BYTE_W-1:0]  DUTY_MAX   = '1;
  localparam logic [LEVEL_W:0]   LEVEL_HALF = (LEVEL_W + 1)'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_TICK   = 2'd1,
    OP_STATUS = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [BYTE_W-1:0] brightness;
    logic              turn_on;
    logic [TIME_W-1:0] fade_time;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] duty;
    logic              duty_written;
    logic [BYTE_W-1:0] stored_brightness;
    logic              stored_on;
  } out_t;

  // 16-bit wrap of fade_time scaled to level units
  function automatic logic [DIV_W-1:0] wrap_div(input logic [TIME_W-1:0] ft);
    logic [DIV_W-1:0] r;
    r = DIV_W'(ft) << FRAC_BITS;
    return r;
  endfunction

  function automatic logic [LEVEL_W-1:0] tgt_of(input logic [BYTE_W-1:0] bright,
                                                input logic              on);
    logic [LEVEL_W-1:0] r;
    r = on ? {bright, {FRAC_BITS{1'b0}}} : '0;
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] duty_of(input logic [LEVEL_W-1:0] level);
    logic [LEVEL_W:0] s;
    logic [BYTE_W-1:0] r;
    s = {1'b0, level} + LEVEL_HALF;
    if (s[LEVEL_W:FRAC_BITS] > {1'b0, DUTY_MAX}) begin
      r = DUTY_MAX;
    end else begin
      r = s[FRAC_BITS+BYTE_W-1:FRAC_BITS];
    end
    return r;
  endfunction

endpackage

// ===== sv/linear_fade_dimmer_unit.sv =====
// Linear fade LED dimmer: command decode, fade stepping and serial step divider.
// Fade tick, status: result in the cycle after accept; one per cycle while output free.
// Set with a nonzero fade: input stalled throughout, in a restoring divider that yields
// one quotient bit per cycle.
// Set with zero fade: jumps to the target, result one cycle after accept.
// rst_ni is async, active low: control state and out_valid_o clear; data regs do not.
module linear_fade_dimmer_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lfd_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lfd_pkg::out_t  out_data_o
);

  lfd_pkg::state_e state_q, state_d;

  logic [lfd_pkg::BYTE_W-1:0]         bright_q, bright_d;
  logic                               on_q, on_d;
  logic [lfd_pkg::LEVEL_W-1:0]        level_q, level_d;
  logic signed [lfd_pkg::STEP_W-1:0]  step_q, step_d;
  logic [lfd_pkg::CNT_W-1:0]          cnt_q, cnt_d;

  logic [lfd_pkg::REM_W-1:0]          rem_q, rem_d;
  logic [lfd_pkg::LEVEL_W-1:0]        quo_q, quo_d;
  logic [lfd_pkg::LEVEL_W-1:0]        dvd_q, dvd_d;
  logic [lfd_pkg::DIV_W-1:0]          dvs_q, dvs_d;
  logic                               dneg_q, dneg_d;
  logic                               qneg_q, qneg_d;
  logic                               dnz_q, dnz_d;

  logic                               out_valid_q;
  lfd_pkg::out_t                      out_data_q, out_data_d;

  logic                               in_acc, out_free, out_load, out_written;
  logic [lfd_pkg::DIV_W-1:0]          wrapped;
  logic [lfd_pkg::LEVEL_W-1:0]        in_tgt, tgt;
  logic signed [lfd_pkg::STEP_W-1:0]  delta, delta_abs;
  logic signed [lfd_pkg::SUM_W-1:0]   sum, tgt_s, nl;
  logic [lfd_pkg::REM_W-1:0]          rem_sh;
  logic [lfd_pkg::REM_W:0]            diff;
  logic                               ge;
  logic signed [lfd_pkg::STEP_W-1:0]  quo_s;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != lfd_pkg::ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign wrapped   = lfd_pkg::wrap_div(in_data_i.fade_time);
  assign in_tgt    = lfd_pkg::tgt_of(in_data_i.brightness, in_data_i.turn_on);
  assign delta     = $signed({1'b0, in_tgt}) - $signed({1'b0, level_q});
  assign delta_abs = delta[lfd_pkg::STEP_W-1] ? -delta : delta;

  assign tgt   = lfd_pkg::tgt_of(bright_q, on_q);
  assign tgt_s = $signed({2'b00, tgt});
  assign sum   = $signed({2'b00, level_q}) + lfd_pkg::SUM_W'(step_q);

  // subtract-compare unit of the divider
  assign rem_sh = {rem_q[lfd_pkg::REM_W-2:0], dvd_q[lfd_pkg::LEVEL_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = !diff[lfd_pkg::REM_W];
  assign quo_s  = $signed({1'b0, quo_q});

  always_comb begin
    state_d     = state_q;
    bright_d    = bright_q;
    on_d        = on_q;
    level_d     = level_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    dneg_d      = dneg_q;
    qneg_d      = qneg_q;
    dnz_d       = dnz_q;
    out_load    = 1'b0;
    out_written = 1'b0;
    nl          = sum;

    unique case (state_q)
      lfd_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (lfd_pkg::op_e'(in_data_i.opcode))
            lfd_pkg::OP_SET: begin
              bright_d = in_data_i.brightness;
              on_d     = in_data_i.turn_on;
              if (wrapped == '0) begin
                level_d     = in_tgt;
                step_d      = '0;
                out_load    = 1'b1;
                out_written = 1'b1;
              end else begin
                dvd_d   = delta_abs[lfd_pkg::LEVEL_W-1:0];
                dneg_d  = delta[lfd_pkg::STEP_W-1];
                dnz_d   = (delta != '0);
                qneg_d  = delta[lfd_pkg::STEP_W-1] ^ wrapped[lfd_pkg::DIV_W-1];
                dvs_d   = wrapped[lfd_pkg::DIV_W-1] ? -wrapped : wrapped;
                rem_d   = '0;
                quo_d   = '0;
                cnt_d   = lfd_pkg::CNT_W'(lfd_pkg::LEVEL_W - 1);
                state_d = lfd_pkg::ST_DIV;
              end
            end
            lfd_pkg::OP_TICK: begin
              out_load = 1'b1;
              if (level_q != tgt) begin
                out_written = 1'b1;
                if ((!step_q[lfd_pkg::STEP_W-1] && step_q != '0 && sum > tgt_s) ||
                    (step_q[lfd_pkg::STEP_W-1] && sum < tgt_s)) begin
                  nl = tgt_s;
                end
                if (nl[lfd_pkg::SUM_W-1]) begin
                  nl = '0;
                end
                level_d = nl[lfd_pkg::LEVEL_W-1:0];
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      lfd_pkg::ST_DIV: begin
        rem_d = ge ? diff[lfd_pkg::REM_W-1:0] : rem_sh;
        quo_d = {quo_q[lfd_pkg::LEVEL_W-2:0], ge};
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = lfd_pkg::ST_DONE;
        end
      end
      lfd_pkg::ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          if (quo_q == '0) begin
            step_d = !dnz_q ? '0 : (dneg_q ? '1 : lfd_pkg::STEP_W'(1));
          end else begin
            step_d = qneg_q ? -quo_s : quo_s;
          end
          state_d = lfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_d.duty              = lfd_pkg::duty_of(level_d);
    out_data_d.duty_written      = out_written;
    out_data_d.stored_brightness = bright_d;
    out_data_d.stored_on         = on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfd_pkg::ST_IDLE;
      bright_q    <= '0;
      on_q        <= 1'b0;
      level_q     <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bright_q    <= bright_d;
      on_q        <= on_d;
      level_q     <= level_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    dneg_q <= dneg_d;
    qneg_q <= qneg_d;
    dnz_q  <= dnz_d;
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/lfd_checker.sv =====
// Port-level checker for the linear fade dimmer, bound to the top level.
module lfd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input lfd_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input lfd_pkg::out_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.opcode != lfd_pkg::OP_SET |=> out_valid_o)
    else $error("tick or status transaction without result next cycle");

  a_status_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.opcode == lfd_pkg::OP_STATUS ||
               in_data_i.opcode == lfd_pkg::OP_SPARE)
    |=> out_valid_o && !out_data_o.duty_written)
    else $error("status transaction reported a duty write");

  a_jump_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.opcode == lfd_pkg::OP_SET &&
    lfd_pkg::wrap_div(in_data_i.fade_time) == '0
    |=> out_valid_o && out_data_o.duty_written &&
        out_data_o.stored_brightness == $past(in_data_i.brightness) &&
        out_data_o.stored_on == $past(in_data_i.turn_on))
    else $error("zero-fade set did not jump to target");

endmodule

bind linear_fade_dimmer_unit lfd_checker u_lfd_checker (.*);
